/* rtl/core/sfcpq_pkg.sv */
// Shared types and constants for the stable four-class priority queue.
package sfcpq_pkg;

  // Operation codes carried in the input beat.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // Stored class codes are the class number minus one, so they fit two bits.
  localparam logic [1:0] CLS_AGED_AGGR  = 2'd0;
  localparam logic [1:0] CLS_YOUNG_AGGR = 2'd1;
  localparam logic [1:0] CLS_AGED_ONLY  = 2'd2;
  localparam logic [1:0] CLS_OTHER      = 2'd3;

  localparam logic [7:0] THRESHOLD_RESET = 8'd60;

  typedef struct packed {
    logic        operation;
    logic [15:0] patient_tag;
    logic [7:0]  age;
    logic        aggravated;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_tag;
    logic [7:0]  out_age;
    logic        out_aggravated;
    logic [2:0]  out_class;
  } out_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [7:0]  age;
    logic        aggr;
    logic [1:0]  cls;
  } entry_t;

endpackage

/* rtl/core/sfcpq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module sfcpq_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/stable_four_class_priority_queue.sv */
// Top level of the stable four-class priority queue: sequencer, pointers and entry RAM.
//
//   Channel  Ports                         Handshake
//   -------  ----------------------------  -----------------------------------------
//   input    start, busy, in_data          beat taken at an edge with start & !busy
//   result   out_strobe, out_data          beat shown for one cycle, cannot stall
//   config   cfg_wr_en, cfg_wr_data        threshold written at an edge with enable
//
// A remove from a non-empty queue holds busy through the pop state. An insert into an
// empty queue and a refused beat do not raise busy at all. An insert into a non-empty
// queue holds busy while each stored entry of a less urgent class moves back one place,
// then while the new entry is written; each move is one read and one write through the
// single read port of the entry RAM. The result beat appears in the first cycle with
// busy low after the accepting edge, which is the very next cycle for a beat that never
// raises busy. Reset (rst_n low at a clock edge) empties the queue and loads the
// threshold with 60; the RAM itself is not cleared, since only slots between the head
// and tail pointers are ever read.
module stable_four_class_priority_queue
  import sfcpq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_t        in_data,
  output logic       out_strobe,
  output out_t       out_data,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1) > 0 ? $clog2(CAPACITY + 1) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_POP     = 3'd1;
  localparam logic [2:0] ST_INS_RD  = 3'd2;
  localparam logic [2:0] ST_INS_CMP = 3'd3;
  localparam logic [2:0] ST_INS_PUT = 3'd4;

  // The store is a ring in the RAM: head_r is the most urgent slot, the oldest of its
  // class, and tail_r the first free slot. Entries between them are kept sorted by class.
  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  entry_t           new_entry_r, new_entry_nxt;
  logic [7:0]       thr_r, thr_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [$bits(entry_t)-1:0] rd_raw;
  entry_t           rd_entry;
  entry_t           in_entry;
  logic             aged;

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] p);
    return (p == IDX_LAST) ? '0 : p + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] p);
    return (p == '0) ? IDX_LAST : p - IDX_W'(1);
  endfunction

  sfcpq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_entry = entry_t'(rd_raw);

  // In idle the read port looks at the head so that a remove finds it registered
  // in the pop state; during an insert it looks at the slot just ahead of the hole.
  assign rd_addr = (state_r == ST_IDLE) ? head_r : idx_prev(cur_r);

  // Class of the incoming beat, from the age threshold and the flag.
  always_comb begin
    aged              = (in_data.age >= thr_r);
    in_entry.tag      = in_data.patient_tag;
    in_entry.age      = in_data.age;
    in_entry.aggr     = in_data.aggravated;
    if (aged) begin
      in_entry.cls = in_data.aggravated ? CLS_AGED_AGGR : CLS_AGED_ONLY;
    end else begin
      in_entry.cls = in_data.aggravated ? CLS_YOUNG_AGGR : CLS_OTHER;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    rem_nxt       = rem_r;
    new_entry_nxt = new_entry_r;
    thr_nxt       = cfg_wr_en ? cfg_wr_data : thr_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = cur_r;
    wr_data       = new_entry_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_data.operation == OP_REMOVE) begin
            if (count_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_nxt        = '0;
              out_nxt.status = STATUS_EMPTY;
            end else begin
              state_nxt = ST_POP;
            end
          end else if (count_r == CNT_FULL) begin
            out_valid_nxt  = 1'b1;
            out_nxt        = '0;
            out_nxt.status = STATUS_FULL;
          end else begin
            new_entry_nxt = in_entry;
            if (count_r == '0) begin
              // Empty queue: the entry goes straight into the free slot.
              wr_en             = 1'b1;
              wr_addr           = tail_r;
              wr_data           = in_entry;
              tail_nxt          = idx_next(tail_r);
              count_nxt         = count_r + CNT_W'(1);
              out_valid_nxt     = 1'b1;
              out_nxt           = '0;
              out_nxt.status    = STATUS_DONE;
              out_nxt.out_class = {1'b0, in_entry.cls} + 3'd1;
            end else begin
              cur_nxt   = tail_r;
              rem_nxt   = count_r;
              state_nxt = ST_INS_RD;
            end
          end
        end
      end

      ST_INS_RD: begin
        state_nxt = ST_INS_CMP;
      end

      ST_INS_CMP: begin
        if (rd_entry.cls > new_entry_r.cls) begin
          // A less urgent entry moves back into the hole.
          wr_en     = 1'b1;
          wr_addr   = cur_r;
          wr_data   = rd_entry;
          cur_nxt   = idx_prev(cur_r);
          rem_nxt   = rem_r - CNT_W'(1);
          state_nxt = (rem_r == CNT_W'(1)) ? ST_INS_PUT : ST_INS_RD;
        end else begin
          wr_en             = 1'b1;
          tail_nxt          = idx_next(tail_r);
          count_nxt         = count_r + CNT_W'(1);
          out_valid_nxt     = 1'b1;
          out_nxt           = '0;
          out_nxt.status    = STATUS_DONE;
          out_nxt.out_class = {1'b0, new_entry_r.cls} + 3'd1;
          state_nxt         = ST_IDLE;
        end
      end

      ST_INS_PUT: begin
        // Every stored entry was less urgent: the new one becomes the head slot.
        wr_en             = 1'b1;
        tail_nxt          = idx_next(tail_r);
        count_nxt         = count_r + CNT_W'(1);
        out_valid_nxt     = 1'b1;
        out_nxt           = '0;
        out_nxt.status    = STATUS_DONE;
        out_nxt.out_class = {1'b0, new_entry_r.cls} + 3'd1;
        state_nxt         = ST_IDLE;
      end

      ST_POP: begin
        out_valid_nxt          = 1'b1;
        out_nxt.status         = STATUS_DONE;
        out_nxt.out_tag        = rd_entry.tag;
        out_nxt.out_age        = rd_entry.age;
        out_nxt.out_aggravated = rd_entry.aggr;
        out_nxt.out_class      = {1'b0, rd_entry.cls} + 3'd1;
        head_nxt               = idx_next(head_r);
        count_nxt              = count_r - CNT_W'(1);
        state_nxt              = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      thr_r       <= THRESHOLD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    rem_r       <= rem_nxt;
    new_entry_r <= new_entry_nxt;
    out_r       <= out_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_valid_r;
  assign out_data   = out_r;

endmodule
